// File: rtl/core/sha_pkg.sv
// sha_pkg: shared types and constants for the service handle allocator.
// Holds operation codes, field widths, the controller state type and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package sha_pkg;

  // Field widths
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned LOCAL_W  = 24;
  localparam int unsigned HARBOR_W = 8;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned ENTRY_W  = LOCAL_W + 1;  // valid mark over local handle

  // Largest local handle; the counter wraps from here back to 1
  localparam logic [LOCAL_W-1:0]  LOCAL_MAX   = 24'hFF_FFFF;
  localparam logic [HARBOR_W-1:0] HARBOR_MASK = 8'hFF;

  // Operation codes (code 3 has no meaning)
  localparam logic [FUNC_W-1:0] FUNC_REGISTER = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RETIRE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP   = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,  // sweep the table after reset
    ST_IDLE,   // waiting for a transaction
    ST_READ,   // table read in flight
    ST_CHECK,  // table entry available
    ST_RESP    // result waiting for the output register
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic clear_step;  // write one empty entry of the sweep
    logic capture;     // take the input transaction
    logic advance;     // move the probe on to the next handle
    logic take_slot;   // store the candidate handle in the probed slot
    logic free_slot;   // clear the probed slot
    logic set_ok;      // mark the result as a success
    logic load_out;    // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;   // sweep reaches the last slot
    logic op_register;  // captured operation is a register
    logic op_retire;    // captured operation is a retire
    logic slot_free;    // probed slot holds no entry
    logic hit;          // probed slot holds the captured handle
    logic probe_last;   // probe has visited every slot
  } sts_t;

endpackage

// File: rtl/core/service_handle_allocator.sv
// service_handle_allocator: top level, hashed handle table allocator.
// Depends on sha_pkg, sha_ctrl, sha_datapath (which holds sha_ram).
//
//   Channel   Direction  Signals                                   Handshake
//   input     in         func_i, handle_i                          in_valid_i / in_ready_o
//   result    out        result_handle_o, slot_index_o, ok_o       out_valid_o / out_ready_i
//   config    in         cfg_wdata_i (harbor id)                   cfg_we_i, no wait
//
// One transaction at a time; each table probe is a read state and then a check state,
// as the slot RAM has a registered read port.
// Register: 1 to SLOTS probes; retire and lookup: one probe of the handle's slot;
// unknown func: straight to the response. A new transaction is taken while a result waits.
// After reset the table is swept empty; in_ready_o stays low during the sweep.
// A stalled result holds the controller in its response state until taken.
`timescale 1ns / 1ps

module service_handle_allocator
  import sha_pkg::*;
#(
  parameter int unsigned SLOTS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [HARBOR_W-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [HANDLE_W-1:0] handle_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [HANDLE_W-1:0] result_handle_o,
  output logic [SLOT_W-1:0]   slot_index_o,
  output logic                ok_o
);

  cmd_t cmd;
  sts_t sts;

  // Controller
  sha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  sha_datapath #(
    .SLOTS(SLOTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .func_i         (func_i),
    .handle_i       (handle_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_handle_o(result_handle_o),
    .slot_index_o   (slot_index_o),
    .ok_o           (ok_o)
  );

endmodule

// File: rtl/core/sha_ram.sv
// sha_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module sha_ram #(
  parameter int unsigned WIDTH = 25,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/sha_datapath.sv
// sha_datapath: slot table, handle counter, harbor register and result registers.
// Depends on sha_pkg and sha_ram; steered by sha_ctrl through cmd_t / sts_t.
`timescale 1ns / 1ps

module sha_datapath
  import sha_pkg::*;
#(
  parameter int unsigned SLOTS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [HARBOR_W-1:0] cfg_wdata_i,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [HANDLE_W-1:0] handle_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic [HANDLE_W-1:0] result_handle_o,
  output logic [SLOT_W-1:0]   slot_index_o,
  output logic                ok_o
);

  localparam int unsigned IDX_W = $clog2(SLOTS);

  // Low eight bits of a slot number
  function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

  logic [HARBOR_W-1:0] harbor_q;
  logic [LOCAL_W-1:0]  next_handle_q, next_handle_d;
  logic [IDX_W-1:0]    clr_q, clr_d;
  logic [FUNC_W-1:0]   op_q, op_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic [LOCAL_W-1:0]  cand_q, cand_d;
  logic [IDX_W-1:0]    addr_q, addr_d;
  logic [IDX_W-1:0]    cnt_q, cnt_d;
  logic [HANDLE_W-1:0] res_handle_q, res_handle_d;
  logic [SLOT_W-1:0]   res_idx_q, res_idx_d;
  logic                res_ok_q, res_ok_d;
  logic [HANDLE_W-1:0] out_handle_q;
  logic [SLOT_W-1:0]   out_idx_q;
  logic                out_ok_q;

  logic [LOCAL_W-1:0]  start_cand;
  logic [LOCAL_W-1:0]  cand_nx;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic                entry_valid;
  logic [LOCAL_W-1:0]  entry_local;

  // Slot table: valid mark over local handle
  sha_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(addr_q),
    .rdata_o(ram_rdata)
  );

  assign entry_valid = ram_rdata[ENTRY_W-1];
  assign entry_local = ram_rdata[LOCAL_W-1:0];

  // Probe start (stored zero reads as one) and next candidate with wrap
  assign start_cand = (next_handle_q == '0) ? LOCAL_W'(1) : next_handle_q;
  assign cand_nx    = (cand_q == LOCAL_MAX) ? LOCAL_W'(1) : cand_q + LOCAL_W'(1);

  // Table write port: sweep, take or free
  always_comb begin
    ram_we    = cmd_i.clear_step | cmd_i.take_slot | cmd_i.free_slot;
    ram_waddr = cmd_i.clear_step ? clr_q : addr_q;
    ram_wdata = cmd_i.take_slot ? {1'b1, cand_q} : '0;
  end

  // Status back to the controller
  always_comb begin
    sts_o.clear_last  = &clr_q;
    sts_o.op_register = (op_q == FUNC_REGISTER);
    sts_o.op_retire   = (op_q == FUNC_RETIRE);
    sts_o.slot_free   = ~entry_valid;
    sts_o.hit         = entry_valid
                        && ({harbor_q & HARBOR_MASK, entry_local} == handle_q);
    sts_o.probe_last  = &cnt_q;
  end

  // Next values of the working registers
  always_comb begin
    clr_d         = clr_q;
    next_handle_d = next_handle_q;
    op_d          = op_q;
    handle_d      = handle_q;
    cand_d        = cand_q;
    addr_d        = addr_q;
    cnt_d         = cnt_q;
    res_handle_d  = res_handle_q;
    res_idx_d     = res_idx_q;
    res_ok_d      = res_ok_q;

    if (cmd_i.clear_step) begin
      clr_d = clr_q + IDX_W'(1);
    end

    if (cmd_i.capture) begin
      op_d         = func_i;
      handle_d     = handle_i;
      cand_d       = start_cand;
      cnt_d        = '0;
      res_handle_d = handle_i;
      res_ok_d     = 1'b0;
      if (func_i == FUNC_REGISTER) begin
        addr_d    = start_cand[IDX_W-1:0];
        res_idx_d = '0;
      end else begin
        addr_d    = handle_i[IDX_W-1:0];
        res_idx_d = (func_i == FUNC_RETIRE || func_i == FUNC_LOOKUP)
                    ? slot_of(handle_i[IDX_W-1:0]) : '0;
      end
    end

    if (cmd_i.advance) begin
      cand_d = cand_nx;
      addr_d = cand_nx[IDX_W-1:0];
      cnt_d  = cnt_q + IDX_W'(1);
    end

    if (cmd_i.take_slot) begin
      next_handle_d = cand_q + LOCAL_W'(1);
      res_handle_d  = {harbor_q & HARBOR_MASK, cand_q};
      res_idx_d     = slot_of(addr_q);
    end

    if (cmd_i.set_ok) begin
      res_ok_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      harbor_q      <= '0;
      next_handle_q <= LOCAL_W'(1);
      clr_q         <= '0;
      cnt_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        harbor_q <= cfg_wdata_i;
      end
      next_handle_q <= next_handle_d;
      clr_q         <= clr_d;
      cnt_q         <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    handle_q     <= handle_d;
    cand_q       <= cand_d;
    addr_q       <= addr_d;
    res_handle_q <= res_handle_d;
    res_idx_q    <= res_idx_d;
    res_ok_q     <= res_ok_d;
    if (cmd_i.load_out) begin
      out_handle_q <= res_handle_q;
      out_idx_q    <= res_idx_q;
      out_ok_q     <= res_ok_q;
    end
  end

  assign result_handle_o = out_handle_q;
  assign slot_index_o    = out_idx_q;
  assign ok_o            = out_ok_q;

  // Local handle zero is never stored
  a_take_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take_slot |-> (cand_q != '0))
    else $error("register stores local handle zero");

endmodule

// File: rtl/core/sha_ctrl.sv
// sha_ctrl: controller state machine for the service handle allocator.
// Depends on sha_pkg; drives sha_datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps

module sha_ctrl
  import sha_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] func_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sts_t              sts_i,
  output cmd_t              cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;
  logic   out_free;
  logic   func_known;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign func_known = (func_i == FUNC_REGISTER) || (func_i == FUNC_RETIRE)
                      || (func_i == FUNC_LOOKUP);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) state_d = func_known ? ST_READ : ST_RESP;
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.op_register && !sts_i.slot_free && !sts_i.probe_last) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clear_step = 1'b1;
      ST_IDLE:  cmd_o.capture    = in_fire;
      ST_READ:  ;
      ST_CHECK: begin
        if (sts_i.op_register) begin
          cmd_o.take_slot = sts_i.slot_free;
          cmd_o.set_ok    = sts_i.slot_free;
          cmd_o.advance   = ~sts_i.slot_free & ~sts_i.probe_last;
        end else begin
          cmd_o.set_ok    = sts_i.hit;
          cmd_o.free_slot = sts_i.hit & sts_i.op_retire;
        end
      end
      ST_RESP:  cmd_o.load_out = out_free;
      default:  ;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A transaction always leads to a read or straight to the response
  a_fire_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_READ || state_q == ST_RESP))
    else $error("accepted transaction not started");

  // The output register is never overwritten while its result waits
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

  // At most one table write source at a time
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.clear_step, cmd_o.take_slot, cmd_o.free_slot}) <= 1)
    else $error("table write conflict");

endmodule
